// ===== rtl/supertrend_indicator_assert.svh =====
// assertion macros for the supertrend indicator
`ifndef SUPERTREND_INDICATOR_ASSERT_SVH
`define SUPERTREND_INDICATOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define STI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define STI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sti_pkg.sv =====
// shared types, widths and codes of the supertrend indicator
package sti_pkg;

    localparam int PRICE_BITS     = 32;
    localparam int FRAC_BITS      = 8;
    localparam int FACTOR_FRAC    = 8;
    localparam int VALUE_BITS     = PRICE_BITS + FRAC_BITS + 1;
    localparam int PERIOD_BITS    = 8;
    localparam int FACTOR_BITS    = 12;
    localparam int COUNT_BITS     = PERIOD_BITS + 1;
    localparam int PROD_BITS      = VALUE_BITS + PERIOD_BITS;
    localparam int DIV_BITS       = (PROD_BITS + 1 > VALUE_BITS + FRAC_BITS) ?
                                    PROD_BITS + 1 : VALUE_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_BITS);
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = FACTOR_BITS;

    localparam logic [PERIOD_BITS-1:0]    ATR_PERIOD_RESET  = PERIOD_BITS'(14);
    localparam logic [FACTOR_BITS-1:0]    BAND_FACTOR_RESET = FACTOR_BITS'(768);
    localparam logic [COUNT_BITS-1:0]     COUNT_CAP = COUNT_BITS'(1) << PERIOD_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ATR_PERIOD  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_FACTOR = CFG_INDEX_BITS'(1);

    localparam logic [1:0] FLIP_NONE = 2'd0;
    localparam logic [1:0] FLIP_UP   = 2'd1;
    localparam logic [1:0] FLIP_DOWN = 2'd2;

    typedef struct packed {
        logic [PRICE_BITS-1:0] bar_high;
        logic [PRICE_BITS-1:0] bar_low;
        logic [PRICE_BITS-1:0] bar_close;
    } t_bar;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] trend_line;
        logic                         direction_up;
        logic [1:0]                   flip;
        logic                         warmed_up;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_SUM,
        S_DIV,
        S_OFFSET,
        S_BAND,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_bar;
        logic calc_range;
        logic calc_sum;
        logic div_step;
        logic div_last;
        logic calc_offset;
        logic calc_band;
        logic calc_update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_needed;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/supertrend_indicator.sv =====
// supertrend indicator top level: wilder atr bands with trend direction per price bar
//
// Input channel: one beat per price bar (high, low, close) on i_bar, handshaked by
// i_bar_valid and o_bar_stall. Output channel: one beat per bar on o_res (trend
// line, direction, flip code, warm-up flag) handshaked by o_res_valid and i_res_stall.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 atr period, 1 band factor); write only while no bar is in flight.
// Each bar passes through the range, sum, offset, band, update and emit states; bars
// that form or smooth the atr (every bar after the period-th) also run the bit-serial
// divide by the period, one quotient bit a cycle, between the sum and offset states.
// A new bar is taken only once the previous result is loaded into the output register.
// The output register lets the next bar be taken while a result beat waits;
// a stalled receiver holds the block only once a second result is ready.
// Reset: synchronous, active low; period 14, factor 3.0, bands and atr zero, trend up.
module supertrend_indicator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sti_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sti_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_bar_valid,
    output logic                               o_bar_stall,
    input  sti_pkg::t_bar                      i_bar,
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output sti_pkg::t_result                   o_res
);

    `include "supertrend_indicator_assert.svh"

    sti_pkg::t_cmd    w_cmd;
    sti_pkg::t_status w_status;
    logic             w_bar_take;
    logic             w_turn_up;
    logic             w_turn_down;

    sti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bar_valid (i_bar_valid),
        .o_bar_stall (o_bar_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sti_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_bar       (i_bar),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_res_stall (i_res_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    assign w_bar_take  = i_bar_valid && !o_bar_stall;
    assign w_turn_up   = o_res_valid && (o_res.flip == sti_pkg::FLIP_UP);
    assign w_turn_down = o_res_valid && (o_res.flip == sti_pkg::FLIP_DOWN);

    `STI_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_bar_take, o_bar_stall, "busy bar taken")
    `STI_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, w_cmd.out_load, w_status.out_free, "slot busy")
    `STI_ASSERT_IMPLY(a_turn_up, i_clk, i_rst_n, w_turn_up, o_res.direction_up, "bad turn up")
    `STI_ASSERT_IMPLY(a_turn_dn, i_clk, i_rst_n, w_turn_down, !o_res.direction_up, "bad turn down")

endmodule

// ===== rtl/sti_ctrl.sv =====
// sequencer of the supertrend indicator: one bar at a time through the datapath
module sti_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_bar_valid,
    output logic             o_bar_stall,
    input  sti_pkg::t_status i_status,
    output sti_pkg::t_cmd    o_cmd
);

    localparam int CNT_BITS = sti_pkg::DIV_CNT_BITS;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(sti_pkg::DIV_BITS - 1);

    sti_pkg::t_state     r_state;
    sti_pkg::t_state     n_state;
    logic [CNT_BITS-1:0] r_div_cnt;
    logic [CNT_BITS-1:0] n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sti_pkg::S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        o_cmd       = '0;
        o_bar_stall = 1'b1;
        case (r_state)
            sti_pkg::S_IDLE: begin
                o_bar_stall = 1'b0;
                if (i_bar_valid) begin
                    o_cmd.load_bar = 1'b1;
                    n_state        = sti_pkg::S_RANGE;
                end
            end
            sti_pkg::S_RANGE: begin
                o_cmd.calc_range = 1'b1;
                n_state          = sti_pkg::S_SUM;
            end
            sti_pkg::S_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_div_cnt      = '0;
                n_state        = i_status.div_needed ? sti_pkg::S_DIV : sti_pkg::S_OFFSET;
            end
            sti_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = (r_div_cnt == CNT_LAST);
                n_div_cnt      = r_div_cnt + CNT_BITS'(1);
                if (o_cmd.div_last) begin
                    n_state = sti_pkg::S_OFFSET;
                end
            end
            sti_pkg::S_OFFSET: begin
                o_cmd.calc_offset = 1'b1;
                n_state           = sti_pkg::S_BAND;
            end
            sti_pkg::S_BAND: begin
                o_cmd.calc_band = 1'b1;
                n_state         = sti_pkg::S_UPDATE;
            end
            sti_pkg::S_UPDATE: begin
                o_cmd.calc_update = 1'b1;
                n_state           = sti_pkg::S_EMIT;
            end
            sti_pkg::S_EMIT: begin
                // wait here only while the output slot still holds an untaken beat
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sti_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sti_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sti_datapath.sv =====
// datapath of the supertrend indicator: atr, bands, trend and output register
module sti_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sti_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sti_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  sti_pkg::t_bar                      i_bar,
    input  sti_pkg::t_cmd                      i_cmd,
    output sti_pkg::t_status                   o_status,
    input  logic                               i_res_stall,
    output logic                               o_res_valid,
    output sti_pkg::t_result                   o_res
);

    localparam int P     = sti_pkg::PRICE_BITS;
    localparam int F     = sti_pkg::FRAC_BITS;
    localparam int V     = sti_pkg::VALUE_BITS;
    localparam int PB    = sti_pkg::PERIOD_BITS;
    localparam int FB    = sti_pkg::FACTOR_BITS;
    localparam int CB    = sti_pkg::COUNT_BITS;
    localparam int PRODB = sti_pkg::PROD_BITS;
    localparam int DB    = sti_pkg::DIV_BITS;
    localparam int OFFP  = FB + V;
    localparam int OFFR  = OFFP - sti_pkg::FACTOR_FRAC;
    localparam logic [OFFR-1:0] OFF_CAP = OFFR'(1) << (V - 1);
    localparam logic signed [V-1:0] VALUE_MAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VALUE_MIN = {1'b1, {(V-1){1'b0}}};

    function automatic logic [P-1:0] abs_diff(input logic [P-1:0] a, input logic [P-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    function automatic logic signed [V-1:0] sat_value(input logic signed [V:0] v);
        if (v[V] != v[V-1]) begin
            sat_value = v[V] ? VALUE_MIN : VALUE_MAX;
        end else begin
            sat_value = v[V-1:0];
        end
    endfunction

    // configuration
    logic [PB-1:0] r_period;
    logic [FB-1:0] r_factor;

    // indicator state
    logic [P-1:0]        r_prev_close;
    logic signed [V-1:0] r_lower;
    logic signed [V-1:0] r_upper;
    logic                r_trend_up;
    logic [V-1:0]        r_avg;
    logic [V-1:0]        r_sum;
    logic [CB-1:0]       r_count;

    // per-bar working registers
    logic [P-1:0]        r_high;
    logic [P-1:0]        r_low;
    logic [P-1:0]        r_close;
    logic [P-1:0]        r_tr;
    logic [PRODB-1:0]    r_prod;
    logic [DB-1:0]       r_div_q;
    logic [PB-1:0]       r_div_rem;
    logic [OFFP-1:0]     r_off_prod;
    logic                r_warmed;
    logic signed [V-1:0] r_basic_lo;
    logic signed [V-1:0] r_basic_hi;
    sti_pkg::t_result    r_res;
    sti_pkg::t_result    r_out;
    logic                r_out_valid;

    logic [PB-1:0]       w_n;
    logic [PB-1:0]       w_n_m1;
    logic [CB-1:0]       w_n_ext;
    logic [P-1:0]        w_d_hl;
    logic [P-1:0]        w_d_hp;
    logic [P-1:0]        w_d_lp;
    logic [P-1:0]        w_tr;
    logic [PRODB-1:0]    w_prod;
    logic                w_idx_nonzero;
    logic                w_in_warmup;
    logic                w_at_period;
    logic [V-1:0]        w_sum_next;
    logic [DB-1:0]       w_dividend;
    logic [PB:0]         w_rem_shift;
    logic                w_rem_ge;
    logic [PB:0]         w_rem_diff;
    logic [PB-1:0]       w_rem_next;
    logic [DB-1:0]       w_q_next;
    logic                w_warmed;
    logic [V-1:0]        w_atr;
    logic [OFFP-1:0]     w_off_prod;
    logic [OFFR-1:0]     w_off_raw;
    logic [OFFR-1:0]     w_off_sel;
    logic [V-1:0]        w_off;
    logic [P:0]          w_hl_sum;
    logic [V-1:0]        w_mid_full;
    logic [V-2:0]        w_mid;
    logic signed [V:0]   w_lo_wide;
    logic signed [V:0]   w_hi_wide;
    logic signed [V-1:0] w_pc_fx;
    logic signed [V-1:0] w_c_fx;
    logic signed [V-1:0] w_new_lo;
    logic signed [V-1:0] w_new_hi;
    logic                w_trend_next;
    logic [1:0]          w_flip;

    // period of zero behaves as one
    assign w_n     = (r_period == '0) ? PB'(1) : r_period;
    assign w_n_m1  = w_n - PB'(1);
    assign w_n_ext = {1'b0, w_n};

    // true range
    assign w_d_hl = abs_diff(r_high, r_low);
    assign w_d_hp = abs_diff(r_high, r_prev_close);
    assign w_d_lp = abs_diff(r_low, r_prev_close);
    always_comb begin
        w_tr = w_d_hl;
        if (w_d_hp > w_tr) begin
            w_tr = w_d_hp;
        end
        if (w_d_lp > w_tr) begin
            w_tr = w_d_lp;
        end
    end

    assign w_prod = {{PB{1'b0}}, r_avg} * {{V{1'b0}}, w_n_m1};

    // warm-up sum and divider load
    assign w_idx_nonzero = (r_count != '0);
    assign w_in_warmup   = (r_count <= w_n_ext);
    assign w_at_period   = (r_count == w_n_ext);
    assign w_sum_next    = r_sum + V'(r_tr);
    assign w_dividend    = w_at_period ? DB'({w_sum_next, {F{1'b0}}})
                                       : DB'(r_prod) + DB'({r_tr, {F{1'b0}}});

    // one quotient bit per step, remainder stays below the period
    assign w_rem_shift = {r_div_rem, r_div_q[DB-1]};
    assign w_rem_ge    = (w_rem_shift >= {1'b0, w_n});
    assign w_rem_diff  = w_rem_shift - {1'b0, w_n};
    assign w_rem_next  = w_rem_ge ? w_rem_diff[PB-1:0] : w_rem_shift[PB-1:0];
    assign w_q_next    = {r_div_q[DB-2:0], w_rem_ge};

    // band offset
    assign w_warmed   = (r_count > w_n_ext);
    assign w_atr      = w_warmed ? r_avg : '0;
    assign w_off_prod = {{FB{1'b0}}, w_atr} * {{V{1'b0}}, r_factor};
    assign w_off_raw  = r_off_prod[OFFP-1:sti_pkg::FACTOR_FRAC];
    assign w_off_sel  = (w_off_raw > OFF_CAP) ? OFF_CAP : w_off_raw;
    assign w_off      = w_off_sel[V-1:0];

    // basic bands around the bar midpoint
    assign w_hl_sum   = {1'b0, r_high} + {1'b0, r_low};
    assign w_mid_full = {w_hl_sum, {F{1'b0}}};
    assign w_mid      = w_mid_full[V-1:1];
    assign w_lo_wide  = $signed({2'b00, w_mid}) - $signed({1'b0, w_off});
    assign w_hi_wide  = $signed({2'b00, w_mid}) + $signed({1'b0, w_off});

    // ratchet and trend, against the bands of the previous bar
    assign w_pc_fx  = $signed({1'b0, r_prev_close, {F{1'b0}}});
    assign w_c_fx   = $signed({1'b0, r_close, {F{1'b0}}});
    assign w_new_lo = (w_pc_fx > r_lower && r_lower > r_basic_lo) ? r_lower : r_basic_lo;
    assign w_new_hi = (w_pc_fx < r_upper && r_upper < r_basic_hi) ? r_upper : r_basic_hi;

    always_comb begin
        w_trend_next = r_trend_up;
        if (w_c_fx > r_upper) begin
            w_trend_next = 1'b1;
        end else if (w_c_fx < r_lower) begin
            w_trend_next = 1'b0;
        end
        w_flip = sti_pkg::FLIP_NONE;
        if (w_trend_next && !r_trend_up) begin
            w_flip = sti_pkg::FLIP_UP;
        end else if (!w_trend_next && r_trend_up) begin
            w_flip = sti_pkg::FLIP_DOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= sti_pkg::ATR_PERIOD_RESET;
            r_factor <= sti_pkg::BAND_FACTOR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sti_pkg::REG_ATR_PERIOD: begin
                    r_period <= i_cfg_data[PB-1:0];
                end
                sti_pkg::REG_BAND_FACTOR: begin
                    r_factor <= i_cfg_data[FB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_close <= '0;
            r_lower      <= '0;
            r_upper      <= '0;
            r_trend_up   <= 1'b1;
            r_avg        <= '0;
            r_sum        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.calc_sum) begin
                if (w_idx_nonzero && w_in_warmup) begin
                    r_sum <= w_sum_next;
                end
                if (r_count < sti_pkg::COUNT_CAP) begin
                    r_count <= r_count + CB'(1);
                end
            end
            if (i_cmd.div_step && i_cmd.div_last) begin
                r_avg <= w_q_next[V-1:0];
            end
            if (i_cmd.calc_update) begin
                r_lower      <= w_new_lo;
                r_upper      <= w_new_hi;
                r_trend_up   <= w_trend_next;
                r_prev_close <= r_close;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bar) begin
            r_high  <= i_bar.bar_high;
            r_low   <= i_bar.bar_low;
            r_close <= i_bar.bar_close;
        end
        if (i_cmd.calc_range) begin
            r_tr   <= w_tr;
            r_prod <= w_prod;
        end
        if (i_cmd.calc_sum) begin
            r_div_q   <= w_dividend;
            r_div_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_q   <= w_q_next;
            r_div_rem <= w_rem_next;
        end
        if (i_cmd.calc_offset) begin
            r_off_prod <= w_off_prod;
            r_warmed   <= w_warmed;
        end
        if (i_cmd.calc_band) begin
            r_basic_lo <= sat_value(w_lo_wide);
            r_basic_hi <= sat_value(w_hi_wide);
        end
        if (i_cmd.calc_update) begin
            r_res.trend_line   <= w_trend_next ? w_new_lo : w_new_hi;
            r_res.direction_up <= w_trend_next;
            r_res.flip         <= w_flip;
            r_res.warmed_up    <= r_warmed;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_status.div_needed = w_idx_nonzero && (r_count >= w_n_ext);
    assign o_status.out_free   = !r_out_valid || !i_res_stall;
    assign o_res_valid         = r_out_valid;
    assign o_res               = r_out;

endmodule
